/* src/rcls_pkg.sv */
// rcls_pkg: shared types, codes and constants of the resource capped list scheduler
// depends on nothing; imported by every module of the block
`timescale 1ns / 1ps

package rcls_pkg;

    localparam int MAX_NODES_DEF   = 64;
    localparam int MAX_WORKERS_DEF = 8;
    localparam int NUM_ENGINES     = 3;
    localparam int SLOT_CNT_W      = 7;

    localparam logic [1:0] MODE_NODE = 2'd0;
    localparam logic [1:0] MODE_EDGE = 2'd1;
    localparam logic [1:0] MODE_RUN  = 2'd2;

    localparam logic [1:0] ENG_MATRIX = 2'd0;
    localparam logic [1:0] ENG_VECTOR = 2'd1;
    localparam logic [1:0] ENG_DMA    = 2'd2;

    localparam logic [1:0] CFG_CAP_MATRIX = 2'd0;
    localparam logic [1:0] CFG_CAP_VECTOR = 2'd1;
    localparam logic [1:0] CFG_CAP_DMA    = 2'd2;

    localparam logic [3:0] CAP_MATRIX_RST = 4'd1;
    localparam logic [3:0] CAP_VECTOR_RST = 4'd4;
    localparam logic [3:0] CAP_DMA_RST    = 4'd1;

    typedef struct packed {
        logic [1:0] mode;
        logic [1:0] engine_class;
        logic [5:0] pred_index;
    } in_item_t;

    typedef struct packed {
        logic [5:0] slot_index;
        logic [1:0] engine;
        logic [2:0] worker;
        logic [5:0] node_index;
        logic       last_in_slot;
        logic       last_of_schedule;
    } out_item_t;

    typedef struct packed {
        logic push;
        logic slot_end;
        logic flush;
    } ob_cmd_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SLOT,
        S_RD,
        S_EVAL,
        S_PASS_END,
        S_FLUSH
    } seq_state_t;

    // zero counts as one, anything above the worker limit counts as the limit
    function automatic logic [3:0] cap_clamp(input logic [3:0] c, input logic [3:0] lim);
        logic [3:0] r;
        r = c;
        if (c == 4'd0)
        begin
            r = 4'd1;
        end
        if (c > lim)
        begin
            r = lim;
        end
        return r;
    endfunction

endpackage

/* src/rcls_graph_mem.sv */
// rcls_graph_mem: per node graph word {blocked, engine, predecessor mask}
// one write port, one registered read port; uses rcls_pkg
`timescale 1ns / 1ps

module rcls_graph_mem
    import rcls_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF,
    parameter int AW        = $clog2(MAX_NODES),
    parameter int DW        = MAX_NODES + 3
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [MAX_NODES];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* src/rcls_out_buf.sv */
// rcls_out_buf: holds the latest result until its slot and schedule flags are known
// and keeps a registered output stage toward the consumer; uses rcls_pkg
`timescale 1ns / 1ps

module rcls_out_buf
    import rcls_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  ob_cmd_t   cmd,
    input  out_item_t push_item,
    output logic      can_push,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_item
);

    out_item_t pend_reg, pend_next;
    logic      pend_valid_reg, pend_valid_next;
    out_item_t out_reg, out_next;
    logic      out_valid_reg, out_valid_next;
    logic      out_free;

    assign out_free = !out_valid_reg || !out_stall;
    assign can_push = !pend_valid_reg || out_free;

    always_comb
    begin
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        out_next        = out_reg;
        out_valid_next  = out_free ? 1'b0 : out_valid_reg;
        if (cmd.push)
        begin
            if (pend_valid_reg)
            begin
                out_next       = pend_reg;
                out_valid_next = 1'b1;
            end
            pend_next       = push_item;
            pend_valid_next = 1'b1;
        end
        else if (cmd.slot_end)
        begin
            pend_next.last_in_slot = 1'b1;
        end
        else if (cmd.flush)
        begin
            if (pend_valid_reg)
            begin
                out_next                  = pend_reg;
                out_next.last_of_schedule = 1'b1;
                out_valid_next            = 1'b1;
            end
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

endmodule

/* src/rcls_sequencer.sv */
// rcls_sequencer: graph loading, capacity registers and the slot scan sequencer
// one node is checked against the done set per step; uses rcls_pkg
`timescale 1ns / 1ps

module rcls_sequencer
    import rcls_pkg::*;
#(
    parameter int MAX_NODES   = MAX_NODES_DEF,
    parameter int MAX_WORKERS = MAX_WORKERS_DEF,
    parameter int AW          = $clog2(MAX_NODES),
    parameter int DW          = MAX_NODES + 3
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  in_item_t      in_item,
    output logic          in_stall,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [1:0]    cfg_index,
    input  logic [3:0]    cfg_data,
    output logic          mem_we,
    output logic [AW-1:0] mem_waddr,
    output logic [DW-1:0] mem_wdata,
    output logic          mem_re,
    output logic [AW-1:0] mem_raddr,
    input  logic [DW-1:0] mem_rdata,
    input  logic          can_push,
    output ob_cmd_t       cmd,
    output out_item_t     push_item
);

    localparam int CW = $clog2(MAX_NODES + 1);
    localparam int WW = $clog2(MAX_WORKERS + 1);
    localparam logic [CW-1:0] NODES_FULL = CW'(MAX_NODES);
    localparam logic [6:0]    PRED_LIMIT = 7'(MAX_NODES);
    localparam logic [3:0]    WORK_LIMIT = 4'(MAX_WORKERS);

    seq_state_t state_reg, state_next;

    logic [CW-1:0]         node_cnt_reg, node_cnt_next;
    logic [CW-1:0]         idx_reg, idx_next;
    logic [1:0]            pass_eng_reg, pass_eng_next;
    logic [WW-1:0]         fill_reg, fill_next;
    logic [SLOT_CNT_W-1:0] slot_cnt_reg, slot_cnt_next;
    logic                  any_reg, any_next;
    logic [MAX_NODES-1:0]  done_reg, done_next;
    logic [MAX_NODES-1:0]  picked_reg, picked_next;
    logic [MAX_NODES-1:0]  latest_mask_reg, latest_mask_next;
    logic [1:0]            latest_eng_reg, latest_eng_next;
    logic                  latest_blk_reg, latest_blk_next;
    logic [3:0]            cap_reg [NUM_ENGINES];
    logic [3:0]            cap_next [NUM_ENGINES];

    logic                 in_take;
    logic [AW-1:0]        cur;
    logic [AW-1:0]        latest_addr;
    logic [1:0]           new_eng;
    logic [MAX_NODES-1:0] edge_bit;
    logic                 edge_self;
    logic                 edge_far;
    logic                 w_blk;
    logic [1:0]           w_eng;
    logic [MAX_NODES-1:0] w_mask;
    logic [WW-1:0]        cap_sel;
    logic                 node_ok;
    logic                 advance;
    logic                 at_end;

    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign in_take   = in_valid && !in_stall;

    assign cur         = idx_reg[AW-1:0];
    assign latest_addr = AW'(node_cnt_reg - CW'(1));
    assign new_eng     = (in_item.engine_class > ENG_DMA) ? ENG_DMA : in_item.engine_class;
    assign edge_bit    = MAX_NODES'(1) << in_item.pred_index;
    assign edge_self   = (7'(in_item.pred_index) == 7'(node_cnt_reg - CW'(1)));
    assign edge_far    = (7'(in_item.pred_index) >= PRED_LIMIT);

    assign w_blk   = mem_rdata[MAX_NODES+2];
    assign w_eng   = mem_rdata[MAX_NODES+1:MAX_NODES];
    assign w_mask  = mem_rdata[MAX_NODES-1:0];
    assign cap_sel = WW'(cap_clamp(cap_reg[pass_eng_reg], WORK_LIMIT));
    assign node_ok = !done_reg[cur] && !w_blk && ((w_mask & ~done_reg) == '0)
                     && (w_eng == pass_eng_reg) && (fill_reg < cap_sel);
    assign advance = !node_ok || can_push;
    assign at_end  = (idx_reg == node_cnt_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_take && in_item.mode == MODE_RUN)
                begin
                    state_next = S_SLOT;
                end
            end
            S_SLOT:
            begin
                state_next = slot_cnt_reg[SLOT_CNT_W-1] ? S_FLUSH : S_RD;
            end
            S_RD:
            begin
                state_next = at_end ? S_PASS_END : S_EVAL;
            end
            S_EVAL:
            begin
                if (advance)
                begin
                    state_next = S_RD;
                end
            end
            S_PASS_END:
            begin
                if (pass_eng_reg != ENG_DMA)
                begin
                    state_next = S_RD;
                end
                else
                begin
                    state_next = any_reg ? S_SLOT : S_FLUSH;
                end
            end
            S_FLUSH:
            begin
                if (can_push)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath and commands
    always_comb
    begin
        node_cnt_next    = node_cnt_reg;
        idx_next         = idx_reg;
        pass_eng_next    = pass_eng_reg;
        fill_next        = fill_reg;
        slot_cnt_next    = slot_cnt_reg;
        any_next         = any_reg;
        done_next        = done_reg;
        picked_next      = picked_reg;
        latest_mask_next = latest_mask_reg;
        latest_eng_next  = latest_eng_reg;
        latest_blk_next  = latest_blk_reg;
        cap_next         = cap_reg;
        mem_we           = 1'b0;
        mem_waddr        = node_cnt_reg[AW-1:0];
        mem_wdata        = {latest_blk_reg, latest_eng_reg, latest_mask_reg};
        mem_re           = 1'b0;
        mem_raddr        = cur;
        cmd              = '0;
        push_item.slot_index       = slot_cnt_reg[5:0];
        push_item.engine           = pass_eng_reg;
        push_item.worker           = 3'(fill_reg);
        push_item.node_index       = 6'(idx_reg);
        push_item.last_in_slot     = 1'b0;
        push_item.last_of_schedule = 1'b0;

        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_CAP_MATRIX: cap_next[0] = cfg_data;
                CFG_CAP_VECTOR: cap_next[1] = cfg_data;
                CFG_CAP_DMA:    cap_next[2] = cfg_data;
                default:        ;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    unique case (in_item.mode)
                        MODE_NODE:
                        begin
                            if (node_cnt_reg != NODES_FULL)
                            begin
                                mem_we           = 1'b1;
                                mem_waddr        = node_cnt_reg[AW-1:0];
                                mem_wdata        = {1'b0, new_eng, {MAX_NODES{1'b0}}};
                                latest_mask_next = '0;
                                latest_eng_next  = new_eng;
                                latest_blk_next  = 1'b0;
                                node_cnt_next    = node_cnt_reg + CW'(1);
                            end
                        end
                        MODE_EDGE:
                        begin
                            if (node_cnt_reg != '0 && !edge_self)
                            begin
                                latest_mask_next = latest_mask_reg | edge_bit;
                                latest_blk_next  = latest_blk_reg | edge_far;
                                mem_we           = 1'b1;
                                mem_waddr        = latest_addr;
                                mem_wdata        = {latest_blk_next, latest_eng_reg,
                                                    latest_mask_next};
                            end
                        end
                        MODE_RUN:
                        begin
                            slot_cnt_next = '0;
                        end
                        default: ;
                    endcase
                end
            end
            S_SLOT:
            begin
                pass_eng_next = ENG_MATRIX;
                idx_next      = '0;
                fill_next     = '0;
                any_next      = 1'b0;
            end
            S_RD:
            begin
                mem_re = !at_end;
            end
            S_EVAL:
            begin
                if (advance)
                begin
                    idx_next = idx_reg + CW'(1);
                end
                if (node_ok && can_push)
                begin
                    cmd.push         = 1'b1;
                    picked_next[cur] = 1'b1;
                    fill_next        = fill_reg + WW'(1);
                    any_next         = 1'b1;
                end
            end
            S_PASS_END:
            begin
                if (pass_eng_reg != ENG_DMA)
                begin
                    pass_eng_next = pass_eng_reg + 2'd1;
                    idx_next      = '0;
                    fill_next     = '0;
                end
                else if (any_reg)
                begin
                    cmd.slot_end  = 1'b1;
                    done_next     = done_reg | picked_reg;
                    picked_next   = '0;
                    slot_cnt_next = slot_cnt_reg + SLOT_CNT_W'(1);
                end
            end
            S_FLUSH:
            begin
                if (can_push)
                begin
                    cmd.flush     = 1'b1;
                    node_cnt_next = '0;
                    done_next     = '0;
                    picked_next   = '0;
                    slot_cnt_next = '0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            node_cnt_reg <= '0;
            idx_reg      <= '0;
            pass_eng_reg <= ENG_MATRIX;
            fill_reg     <= '0;
            slot_cnt_reg <= '0;
            any_reg      <= 1'b0;
            done_reg     <= '0;
            picked_reg   <= '0;
            cap_reg[0]   <= CAP_MATRIX_RST;
            cap_reg[1]   <= CAP_VECTOR_RST;
            cap_reg[2]   <= CAP_DMA_RST;
        end
        else
        begin
            state_reg    <= state_next;
            node_cnt_reg <= node_cnt_next;
            idx_reg      <= idx_next;
            pass_eng_reg <= pass_eng_next;
            fill_reg     <= fill_next;
            slot_cnt_reg <= slot_cnt_next;
            any_reg      <= any_next;
            done_reg     <= done_next;
            picked_reg   <= picked_next;
            cap_reg      <= cap_next;
        end
    end

    always_ff @(posedge clk)
    begin
        latest_mask_reg <= latest_mask_next;
        latest_eng_reg  <= latest_eng_next;
        latest_blk_reg  <= latest_blk_next;
    end

endmodule

/* src/resource_capped_list_scheduler_unit.sv */
// Node and edge requests are taken while idle; a run request is not answered until done.
// A run scans every loaded node once per engine per slot; each node is read through the
// graph memory read port and then evaluated, and a ready node waits while the output is held.
// Results trail by one entry and each leaves on the next push or when the run ends.
// Reset empties the graph, restores the capacities to 1, 4, 1; no clearing pass is needed.
`timescale 1ns / 1ps

module resource_capped_list_scheduler_unit
    import rcls_pkg::*;
#(
    parameter int MAX_NODES   = MAX_NODES_DEF,
    parameter int MAX_WORKERS = MAX_WORKERS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_item_t  in_item,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_item,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [3:0] cfg_data
);

    localparam int AW = $clog2(MAX_NODES);
    localparam int DW = MAX_NODES + 3;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [DW-1:0] mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    logic [DW-1:0] mem_rdata;
    logic          can_push;
    ob_cmd_t       cmd;
    out_item_t     push_item;

    rcls_graph_mem #(
        .MAX_NODES(MAX_NODES),
        .AW(AW),
        .DW(DW)
    ) u_mem (
        .clk(clk),
        .we(mem_we),
        .waddr(mem_waddr),
        .wdata(mem_wdata),
        .re(mem_re),
        .raddr(mem_raddr),
        .rdata(mem_rdata)
    );

    rcls_sequencer #(
        .MAX_NODES(MAX_NODES),
        .MAX_WORKERS(MAX_WORKERS),
        .AW(AW),
        .DW(DW)
    ) u_seq (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_item(in_item),
        .in_stall(in_stall),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .mem_we(mem_we),
        .mem_waddr(mem_waddr),
        .mem_wdata(mem_wdata),
        .mem_re(mem_re),
        .mem_raddr(mem_raddr),
        .mem_rdata(mem_rdata),
        .can_push(can_push),
        .cmd(cmd),
        .push_item(push_item)
    );

    rcls_out_buf u_out (
        .clk(clk),
        .rst_n(rst_n),
        .cmd(cmd),
        .push_item(push_item),
        .can_push(can_push),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_item(out_item)
    );

endmodule
